@@ rtl/core/gbn_pkg.sv @@
// Package for the go-back-N link controller core.
// Holds the word types, event and action codes, and the controller-datapath signals.
// No dependencies.
`default_nettype none

package gbn_pkg;

    localparam int SEQ_W    = 3;
    localparam int SLOT_W   = 2;
    localparam int LEN_W    = 9;
    localparam int CNT_W    = 3;
    localparam int WINDOW_SLOTS = 4;

    localparam logic [LEN_W-1:0] PACKET_BYTES  = 9'd256;
    localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 9'd5;
    localparam logic [LEN_W-1:0] DATA_OVERHEAD = 9'd7;
    localparam logic [LEN_W-1:0] DATA_HDR_LEN  = 9'd3;
    localparam logic [LEN_W-1:0] ACK_LEN       = 9'd2;
    localparam logic [CNT_W-1:0] WINDOW_FULL   = 3'd4;

    localparam logic [1:0] CMD_PACKET  = 2'd0;
    localparam logic [1:0] CMD_PHYS    = 2'd1;
    localparam logic [1:0] CMD_FRAME   = 2'd2;
    localparam logic [1:0] CMD_TIMEOUT = 2'd3;

    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    localparam logic [2:0] ACT_SEND    = 3'd0;
    localparam logic [2:0] ACT_ACK     = 3'd1;
    localparam logic [2:0] ACT_DELIVER = 3'd2;
    localparam logic [2:0] ACT_STOP    = 3'd3;
    localparam logic [2:0] ACT_GATE    = 3'd4;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [LEN_W-1:0] packet_len;
        logic [LEN_W-1:0] frame_len;
        logic             frame_crc_ok;
        logic [1:0]       frame_kind;
        logic [SEQ_W-1:0] frame_seq;
        logic [SEQ_W-1:0] ack_num;
    } evt_word_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [SEQ_W-1:0]  seq_num;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  byte_count;
        logic              net_enable;
        logic              last;
    } act_word_t;

    typedef struct packed {
        logic capture;
        logic emit_body;
        logic emit_gate;
    } ctl_cmd_t;

    typedef struct packed {
        logic body_valid;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/gbn_ctrl.sv @@
// Controller state machine of the go-back-N link controller.
// Sequences one event into its results and the closing gate word; uses gbn_pkg.
`default_nettype none

module gbn_ctrl
    import gbn_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       evt_valid,
    output logic            evt_stall,
    input  wire dp_status_t status,
    output ctl_cmd_t        ctl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ctl.capture   = 1'b0;
        ctl.emit_body = 1'b0;
        ctl.emit_gate = 1'b0;
        evt_stall     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                evt_stall   = 1'b0;
                ctl.capture = evt_valid;
                if (evt_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.out_free)
                begin
                    if (status.body_valid)
                    begin
                        ctl.emit_body = 1'b1;
                    end
                    else
                    begin
                        ctl.emit_gate = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/gbn_datapath.sv @@
// Datapath of the go-back-N link controller: window state, slot lengths and output register.
// Builds each result word on command from gbn_ctrl; uses gbn_pkg.
`default_nettype none

module gbn_datapath
    import gbn_pkg::*;
#(
    parameter logic [LEN_W-1:0] MAX_PACKET_LEN = PACKET_BYTES
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire evt_word_t evt,
    input  wire ctl_cmd_t  ctl,
    output dp_status_t     status,
    output logic           act_valid,
    output act_word_t      act,
    input  wire logic      act_stall
);

    evt_word_t        ev_reg;
    logic [SEQ_W-1:0] ack_exp_reg;
    logic [SEQ_W-1:0] next_send_reg;
    logic [SEQ_W-1:0] recv_exp_reg;
    logic [CNT_W-1:0] buffered_reg;
    logic             phys_ready_reg;
    logic [CNT_W-1:0] step_reg;
    logic [LEN_W-1:0] slot_len_reg [WINDOW_SLOTS];
    logic             out_valid_reg;
    act_word_t        out_reg;

    logic [LEN_W-1:0] plen_sat;
    logic [LEN_W-1:0] dlen_raw;
    logic [LEN_W-1:0] dlen_sat;
    logic             frame_good;
    logic             in_win;
    logic [SEQ_W-1:0] resend_seq;
    logic             body_valid;
    act_word_t        body_word;
    act_word_t        gate_word;

    assign plen_sat   = (ev_reg.packet_len > MAX_PACKET_LEN) ?
                        MAX_PACKET_LEN : ev_reg.packet_len;
    assign dlen_raw   = (ev_reg.frame_len >= DATA_OVERHEAD) ?
                        (ev_reg.frame_len - DATA_OVERHEAD) : '0;
    assign dlen_sat   = (dlen_raw > MAX_PACKET_LEN) ? MAX_PACKET_LEN : dlen_raw;
    assign frame_good = (ev_reg.frame_len >= MIN_FRAME_LEN) && ev_reg.frame_crc_ok;
    assign resend_seq = ack_exp_reg + SEQ_W'(step_reg);

    always_comb
    begin
        if (ack_exp_reg <= next_send_reg)
        begin
            in_win = (ack_exp_reg <= ev_reg.ack_num) && (ev_reg.ack_num < next_send_reg);
        end
        else
        begin
            in_win = (ack_exp_reg <= ev_reg.ack_num) || (ev_reg.ack_num < next_send_reg);
        end
    end

    always_comb
    begin
        body_valid = 1'b0;
        body_word  = '0;
        unique case (ev_reg.cmd)
            CMD_PACKET:
            begin
                body_valid           = (step_reg == '0) && (buffered_reg < WINDOW_FULL);
                body_word.action     = ACT_SEND;
                body_word.seq_num    = next_send_reg;
                body_word.slot       = next_send_reg[SLOT_W-1:0];
                body_word.byte_count = DATA_HDR_LEN + plen_sat;
            end
            CMD_PHYS:
            begin
                body_valid = 1'b0;
            end
            CMD_FRAME:
            begin
                if (frame_good && (ev_reg.frame_kind == KIND_ACK))
                begin
                    body_valid        = (buffered_reg != '0) && in_win;
                    body_word.action  = ACT_STOP;
                    body_word.seq_num = ack_exp_reg;
                end
                else if (frame_good && (ev_reg.frame_kind == KIND_DATA) &&
                         (ev_reg.frame_seq == recv_exp_reg))
                begin
                    body_valid        = (step_reg < CNT_W'(2));
                    body_word.seq_num = ev_reg.frame_seq;
                    if (step_reg == '0)
                    begin
                        body_word.action     = ACT_DELIVER;
                        body_word.byte_count = dlen_sat;
                    end
                    else
                    begin
                        body_word.action     = ACT_ACK;
                        body_word.byte_count = ACK_LEN;
                    end
                end
            end
            CMD_TIMEOUT:
            begin
                body_valid           = (step_reg < buffered_reg);
                body_word.action     = ACT_SEND;
                body_word.seq_num    = resend_seq;
                body_word.slot       = resend_seq[SLOT_W-1:0];
                body_word.byte_count = DATA_HDR_LEN + slot_len_reg[resend_seq[SLOT_W-1:0]];
            end
            default:
            begin
                body_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        gate_word            = '0;
        gate_word.action     = ACT_GATE;
        gate_word.last       = 1'b1;
        gate_word.net_enable = (buffered_reg < WINDOW_FULL) &&
                               (phys_ready_reg || (ev_reg.cmd == CMD_PHYS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_exp_reg    <= '0;
            next_send_reg  <= '0;
            recv_exp_reg   <= '0;
            buffered_reg   <= '0;
            phys_ready_reg <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                step_reg <= '0;
            end
            if (ctl.emit_body)
            begin
                step_reg <= step_reg + CNT_W'(1);
                unique case (ev_reg.cmd)
                    CMD_PACKET:
                    begin
                        buffered_reg   <= buffered_reg + CNT_W'(1);
                        next_send_reg  <= next_send_reg + SEQ_W'(1);
                        phys_ready_reg <= 1'b0;
                    end
                    CMD_FRAME:
                    begin
                        if (ev_reg.frame_kind == KIND_ACK)
                        begin
                            buffered_reg <= buffered_reg - CNT_W'(1);
                            ack_exp_reg  <= ack_exp_reg + SEQ_W'(1);
                        end
                        else if (step_reg != '0)
                        begin
                            phys_ready_reg <= 1'b0;
                            recv_exp_reg   <= recv_exp_reg + SEQ_W'(1);
                        end
                    end
                    CMD_TIMEOUT:
                    begin
                        phys_ready_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (ctl.emit_gate && (ev_reg.cmd == CMD_PHYS))
            begin
                phys_ready_reg <= 1'b1;
            end
            if (ctl.emit_body || ctl.emit_gate)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!act_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            ev_reg <= evt;
        end
        if (ctl.emit_body && (ev_reg.cmd == CMD_PACKET))
        begin
            slot_len_reg[next_send_reg[SLOT_W-1:0]] <= plen_sat;
        end
        if (ctl.emit_body)
        begin
            out_reg <= body_word;
        end
        else if (ctl.emit_gate)
        begin
            out_reg <= gate_word;
        end
    end

    assign status.body_valid = body_valid;
    assign status.out_free   = !out_valid_reg || !act_stall;
    assign act_valid         = out_valid_reg;
    assign act               = out_reg;

endmodule

`default_nettype wire

@@ rtl/core/go_back_n_link_controller_core.sv @@
// Go-back-N link controller core: one link event in, one to five action words out.
// An event is accepted in the idle state; the run state then emits its action words in turn,
// holding while the output is stalled, and each word is registered before it is presented.
// The output register lets the next event be accepted while the gate word waits.
// Reset is asynchronous, active low, and clears the window state and all control.
// Built from gbn_ctrl and gbn_datapath; uses gbn_pkg.
`default_nettype none

module go_back_n_link_controller_core
    import gbn_pkg::*;
#(
    parameter logic [LEN_W-1:0] MAX_PACKET_LEN = PACKET_BYTES
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      evt_valid,
    output logic           evt_stall,
    input  wire evt_word_t evt,
    output logic           act_valid,
    input  wire logic      act_stall,
    output act_word_t      act
);

    ctl_cmd_t   ctl;
    dp_status_t status;

    gbn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .status    (status),
        .ctl       (ctl)
    );

    gbn_datapath #(
        .MAX_PACKET_LEN (MAX_PACKET_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .ctl       (ctl),
        .status    (status),
        .act_valid (act_valid),
        .act       (act),
        .act_stall (act_stall)
    );

endmodule

`default_nettype wire

@@ rtl/core/gbn_checker.sv @@
// Port-level checker for the go-back-N link controller core, bound to the top level.
// Uses gbn_pkg.
`default_nettype none

module gbn_checker
    import gbn_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      evt_valid,
    input wire logic      evt_stall,
    input wire logic      act_valid,
    input wire logic      act_stall,
    input wire act_word_t act
);

    a_act_hold: assert property (@(posedge clk) disable iff (!rst_n)
        act_valid && act_stall |=> act_valid)
        else $error("Stalled output word was dropped.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_stall |=> evt_stall)
        else $error("Event accepted while a run was starting.");

    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        act_valid && !act.last |-> evt_stall)
        else $error("Event accepted before its predecessor's run ended.");

    a_last_is_gate: assert property (@(posedge clk) disable iff (!rst_n)
        act_valid |-> (act.last == (act.action == ACT_GATE)))
        else $error("Final word and gate action disagree.");

    a_enable_on_gate: assert property (@(posedge clk) disable iff (!rst_n)
        act_valid && (act.action != ACT_GATE) |-> !act.net_enable)
        else $error("Network enable set on a non-gate word.");

endmodule

bind go_back_n_link_controller_core gbn_checker u_gbn_checker (.*);

`default_nettype wire

@@ sim/tb_go_back_n_link_controller_core.sv @@
// Self-checking testbench for the go-back-N link controller core.
// Predicts every action word from its own window model and checks them in order.
// Depends on gbn_pkg and go_back_n_link_controller_core.
`default_nettype none

module tb_go_back_n_link_controller_core;
    import gbn_pkg::*;

    localparam logic [1:0] KIND_OTHER    = 2'd0;
    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int         HALF_PERIOD   = 4;

    logic      clk;
    logic      rst_n;
    logic      evt_valid;
    logic      evt_stall;
    evt_word_t evt;
    logic      act_valid;
    logic      act_stall;
    act_word_t act;

    logic [SEQ_W-1:0] tx_ack_seq;
    logic [SEQ_W-1:0] tx_next_seq;
    logic [SEQ_W-1:0] rx_next_seq;
    logic [CNT_W-1:0] tx_buffered;
    logic             phy_ready;
    logic [LEN_W-1:0] slot_len [WINDOW_SLOTS];

    act_word_t   expected_actions [$];
    int unsigned error_count;
    int unsigned burst_left;
    int unsigned stall_left;
    int unsigned stall_mode;
    int unsigned mode_left;

    go_back_n_link_controller_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .act_valid (act_valid),
        .act_stall (act_stall),
        .act       (act)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        return s + 1'b1;
    endfunction

    function automatic bit seq_between(input logic [SEQ_W-1:0] lo, x, hi);
        if (lo <= hi)
            return (lo <= x) && (x < hi);
        return (lo <= x) || (x < hi);
    endfunction

    function automatic void push_action(input logic [2:0] action, input logic [SEQ_W-1:0] seq,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [LEN_W-1:0] count, input logic en, last);
        act_word_t w;
        w.action     = action;
        w.seq_num    = seq;
        w.slot       = slot;
        w.byte_count = count;
        w.net_enable = en;
        w.last       = last;
        expected_actions.push_back(w);
    endfunction

    function automatic void push_send(input logic [SEQ_W-1:0] seq);
        logic [SLOT_W-1:0] idx;
        idx = seq[SLOT_W-1:0];
        push_action(ACT_SEND, seq, idx, DATA_HDR_LEN + slot_len[idx], 1'b0, 1'b0);
        phy_ready = 1'b0;
    endfunction

    function automatic void predict_link_event(input evt_word_t w);
        logic [SEQ_W-1:0] s;
        logic [LEN_W-1:0] len;
        int unsigned      i;
        case (w.cmd)
            CMD_PACKET:
            begin
                if (tx_buffered < WINDOW_FULL)
                begin
                    len = (w.packet_len > PACKET_BYTES) ? PACKET_BYTES : w.packet_len;
                    slot_len[tx_next_seq[SLOT_W-1:0]] = len;
                    tx_buffered = tx_buffered + 1'b1;
                    push_send(tx_next_seq);
                    tx_next_seq = seq_inc(tx_next_seq);
                end
            end
            CMD_PHYS:
            begin
                phy_ready = 1'b1;
            end
            CMD_FRAME:
            begin
                if (w.frame_len >= MIN_FRAME_LEN && w.frame_crc_ok)
                begin
                    if (w.frame_kind == KIND_ACK)
                    begin
                        while (tx_buffered > 0 &&
                               seq_between(tx_ack_seq, w.ack_num, tx_next_seq))
                        begin
                            push_action(ACT_STOP, tx_ack_seq, '0, '0, 1'b0, 1'b0);
                            tx_buffered = tx_buffered - 1'b1;
                            tx_ack_seq  = seq_inc(tx_ack_seq);
                        end
                    end
                    else if (w.frame_kind == KIND_DATA && w.frame_seq == rx_next_seq)
                    begin
                        len = (w.frame_len >= DATA_OVERHEAD) ? w.frame_len - DATA_OVERHEAD : '0;
                        if (len > PACKET_BYTES)
                            len = PACKET_BYTES;
                        push_action(ACT_DELIVER, w.frame_seq, '0, len, 1'b0, 1'b0);
                        push_action(ACT_ACK, w.frame_seq, '0, ACK_LEN, 1'b0, 1'b0);
                        phy_ready   = 1'b0;
                        rx_next_seq = seq_inc(rx_next_seq);
                    end
                end
            end
            default:
            begin
                s = tx_ack_seq;
                for (i = 0; i < tx_buffered; i++)
                begin
                    push_send(s);
                    s = seq_inc(s);
                end
            end
        endcase
        push_action(ACT_GATE, '0, '0, '0, (tx_buffered < WINDOW_FULL) && phy_ready, 1'b1);
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v, got_v);
        if (exp_v != got_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        act_word_t e;
        if (rst_n && act_valid && !act_stall)
        begin
            if (expected_actions.size() == 0)
            begin
                $error("unexpected action word: action %0d seq_num %0d", act.action, act.seq_num);
                error_count++;
            end
            else
            begin
                e = expected_actions.pop_front();
                check_field("action", e.action, act.action);
                check_field("seq_num", e.seq_num, act.seq_num);
                check_field("slot", e.slot, act.slot);
                check_field("byte_count", e.byte_count, act.byte_count);
                check_field("net_enable", e.net_enable, act.net_enable);
                check_field("last", e.last, act.last);
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            act_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            act_stall <= 1'b0;
            if (stall_mode == 1 && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 3);
            else if (stall_mode == 2 && $urandom_range(0, 15) == 0)
                stall_left = $urandom_range(4, 8);
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 150);
        end
        else
            mode_left--;
    end

    function automatic evt_word_t make_event(input logic [1:0] cmd,
                                             input logic [LEN_W-1:0] plen, flen,
                                             input logic crc, input logic [1:0] kind,
                                             input logic [SEQ_W-1:0] fseq, fack);
        evt_word_t w;
        w.cmd          = cmd;
        w.packet_len   = plen;
        w.frame_len    = flen;
        w.frame_crc_ok = crc;
        w.frame_kind   = kind;
        w.frame_seq    = fseq;
        w.ack_num      = fack;
        return w;
    endfunction

    task automatic send_event(input evt_word_t w);
        logic [31:0] r;
        int unsigned gap;
        evt       <= w;
        evt_valid <= 1'b1;
        @(posedge clk);
        while (evt_stall)
            @(posedge clk);
        predict_link_event(w);
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 8);
            if (gap > 0)
            begin
                r = $urandom;
                evt_valid <= 1'b0;
                evt       <= r[$bits(evt_word_t)-1:0];
                repeat (gap) @(negedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic wait_for_idle();
        evt_valid <= 1'b0;
        @(negedge clk);
        while (expected_actions.size() != 0)
            @(negedge clk);
    endtask

    function automatic evt_word_t random_event();
        evt_word_t   w;
        logic [31:0] r;
        int unsigned pick;
        r    = $urandom;
        w    = r[$bits(evt_word_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            w.cmd = CMD_PACKET;
            if ($urandom_range(0, 9) != 0)
                w.packet_len = $urandom_range(0, 256);
        end
        else if (pick < 45)
            w.cmd = CMD_PHYS;
        else if (pick < 85)
        begin
            w.cmd = CMD_FRAME;
            if ($urandom_range(0, 9) != 0)
            begin
                w.frame_crc_ok = 1'b1;
                w.frame_len    = $urandom_range(5, 263);
                if ($urandom_range(0, 1) != 0)
                begin
                    w.frame_kind = KIND_ACK;
                    if (tx_buffered > 0 && $urandom_range(0, 4) != 0)
                        w.ack_num = tx_ack_seq + $urandom_range(0, tx_buffered - 1);
                end
                else
                begin
                    w.frame_kind = KIND_DATA;
                    if ($urandom_range(0, 4) != 0)
                        w.frame_seq = rx_next_seq;
                end
            end
        end
        else
            w.cmd = CMD_TIMEOUT;
        return w;
    endfunction

    task automatic test_window_fill();
        send_event(make_event(CMD_PHYS, 9'd0, 9'd0, 1'b0, KIND_OTHER, 3'd0, 3'd0));
        send_event(make_event(CMD_PACKET, 9'd0, 9'd0, 1'b0, KIND_OTHER, 3'd0, 3'd0));
        send_event(make_event(CMD_PACKET, 9'd256, 9'd0, 1'b0, KIND_OTHER, 3'd0, 3'd0));
        send_event(make_event(CMD_PACKET, 9'd257, 9'd0, 1'b0, KIND_OTHER, 3'd0, 3'd0));
        send_event(make_event(CMD_PACKET, 9'd511, 9'd0, 1'b0, KIND_OTHER, 3'd0, 3'd0));
        send_event(make_event(CMD_PACKET, 9'd100, 9'd0, 1'b0, KIND_OTHER, 3'd0, 3'd0));
    endtask

    task automatic test_timeout_resend();
        send_event(make_event(CMD_TIMEOUT, 9'd0, 9'd0, 1'b0, KIND_OTHER, 3'd0, 3'd0));
    endtask

    task automatic test_bad_frames();
        send_event(make_event(CMD_FRAME, 9'd0, 9'd4, 1'b1, KIND_ACK, 3'd0, 3'd0));
        send_event(make_event(CMD_FRAME, 9'd0, 9'd263, 1'b0, KIND_ACK, 3'd0, 3'd0));
        send_event(make_event(CMD_FRAME, 9'd0, 9'd20, 1'b1, KIND_OTHER, 3'd0, 3'd0));
        send_event(make_event(CMD_FRAME, 9'd0, 9'd20, 1'b1, KIND_RESERVED, 3'd0, 3'd0));
    endtask

    task automatic test_ack_slide();
        send_event(make_event(CMD_FRAME, 9'd0, 9'd5, 1'b1, KIND_ACK, 3'd0, 3'd1));
        send_event(make_event(CMD_FRAME, 9'd0, 9'd5, 1'b1, KIND_ACK, 3'd0, 3'd7));
        send_event(make_event(CMD_FRAME, 9'd0, 9'd5, 1'b1, KIND_ACK, 3'd0, 3'd3));
        send_event(make_event(CMD_TIMEOUT, 9'd0, 9'd0, 1'b0, KIND_OTHER, 3'd0, 3'd0));
    endtask

    task automatic test_data_delivery();
        send_event(make_event(CMD_PHYS, 9'd0, 9'd0, 1'b0, KIND_OTHER, 3'd0, 3'd0));
        send_event(make_event(CMD_FRAME, 9'd0, 9'd5, 1'b1, KIND_DATA, 3'd0, 3'd0));
        send_event(make_event(CMD_FRAME, 9'd0, 9'd7, 1'b1, KIND_DATA, 3'd1, 3'd0));
        send_event(make_event(CMD_FRAME, 9'd0, 9'd263, 1'b1, KIND_DATA, 3'd2, 3'd0));
        send_event(make_event(CMD_FRAME, 9'd0, 9'd511, 1'b1, KIND_DATA, 3'd3, 3'd7));
        send_event(make_event(CMD_FRAME, 9'd0, 9'd40, 1'b1, KIND_DATA, 3'd5, 3'd0));
        send_event(make_event(CMD_FRAME, 9'd0, 9'd6, 1'b1, KIND_DATA, 3'd4, 3'd0));
    endtask

    task automatic test_random_traffic();
        repeat (95) send_event(random_event());
        wait_for_idle();
        repeat (95) send_event(random_event());
    endtask

    initial
    begin
        int unsigned wait_cycles;
        rst_n       = 1'b0;
        evt_valid   = 1'b0;
        evt         = '0;
        act_stall   = 1'b0;
        tx_ack_seq  = '0;
        tx_next_seq = '0;
        rx_next_seq = '0;
        tx_buffered = '0;
        phy_ready   = 1'b0;
        error_count = 0;
        burst_left  = 0;
        stall_left  = 0;
        stall_mode  = 0;
        mode_left   = 40;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_window_fill();
        test_timeout_resend();
        test_bad_frames();
        test_ack_slide();
        test_data_delivery();
        test_random_traffic();

        evt_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_actions.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (expected_actions.size() != 0)
        begin
            $error("%0d action words never arrived", expected_actions.size());
            error_count++;
        end
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
